>>> hdl/multipart_boundary_splitter_macros.svh
// Assertion macros shared by the multipart boundary splitter modules.
// No dependencies; included by the controller and the datapath.
`ifndef MULTIPART_BOUNDARY_SPLITTER_MACROS_SVH
`define MULTIPART_BOUNDARY_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/mbs_pkg.sv
// Shared types and constants for the multipart boundary splitter.
// Used by mbs_control, mbs_datapath and the top level; no dependencies.
package mbs_pkg;

   localparam int MAX_BOUNDARY = 48;
   localparam int MAX_PAD      = 8;
   // Line break, "--", boundary, padding and one trailing CR or dash.
   localparam int HELD_DEPTH   = 2 + 2 + MAX_BOUNDARY + MAX_PAD + 1;

   localparam int BND_IDX_W  = $clog2(MAX_BOUNDARY);
   localparam int HELD_IDX_W = $clog2(HELD_DEPTH);
   localparam int HELD_CNT_W = $clog2(HELD_DEPTH + 1);
   localparam int POS_W      = $clog2(MAX_BOUNDARY + 3);
   localparam int PAD_W      = $clog2(MAX_PAD + 1);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_BODY   = 2'd1,
      CMD_END    = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_DISCARD = 2'd2,
      KIND_FINISH  = 2'd3
   } kind_type;

   // Results still owed for the current item, in delivery order.
   typedef struct packed {
      logic done;
      logic discard;
      logic finish;
      logic content;
   } events_type;

   typedef struct packed {
      logic     capture;
      logic     eval_commit;
      logic     rel_start;
      logic     rel_advance;
      logic     rel_end;
      logic     out_load;
      kind_type out_kind;
      logic     out_last;
      logic     out_from_held;
   } dp_cmd_type;

   typedef struct packed {
      events_type ev;
      logic       reject;
      logic       rel_more;
      logic       rel_last;
      logic       slot_free;
   } dp_status_type;

endpackage

>>> hdl/mbs_control.sv
// Sequencing state machine of the multipart boundary splitter.
// Depends on mbs_pkg and multipart_boundary_splitter_macros.svh.
`include "multipart_boundary_splitter_macros.svh"

module mbs_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_command,
   output logic                  req_stall,
   input  mbs_pkg::dp_status_type dp_status,
   output mbs_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT,
      ST_RELEASE
   } state_type;

   state_type           state_ff, state_in;
   mbs_pkg::events_type pending_ff, pending_in;
   mbs_pkg::events_type src;
   mbs_pkg::events_type rest;
   mbs_pkg::kind_type   first_kind;

   assign req_stall = (state_ff != ST_IDLE);

   // Pick the earliest owed result and what remains after it.
   always_comb begin
      src        = (state_ff == ST_EVAL) ? dp_status.ev : pending_ff;
      rest       = src;
      first_kind = mbs_pkg::KIND_BYTE;
      priority if (src.done) begin
         first_kind = mbs_pkg::KIND_DONE;
         rest.done  = 1'b0;
      end else if (src.discard) begin
         first_kind   = mbs_pkg::KIND_DISCARD;
         rest.discard = 1'b0;
      end else if (src.finish) begin
         first_kind  = mbs_pkg::KIND_FINISH;
         rest.finish = 1'b0;
      end else begin
         first_kind   = mbs_pkg::KIND_BYTE;
         rest.content = 1'b0;
      end
   end

   always_comb begin
      dp_cmd     = '0;
      state_in   = state_ff;
      pending_in = pending_ff;
      unique case (state_ff)
         ST_IDLE: begin
            dp_cmd.capture = req_valid;
            if (req_valid && (req_command == mbs_pkg::CMD_BODY ||
                              req_command == mbs_pkg::CMD_END)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            dp_cmd.eval_commit = 1'b1;
            if (dp_status.reject) begin
               dp_cmd.rel_start = 1'b1;
               pending_in       = '0;
               state_in         = ST_RELEASE;
            end else if (src == '0) begin
               pending_in = '0;
               state_in   = ST_IDLE;
            end else if (dp_status.slot_free) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_kind = first_kind;
               dp_cmd.out_last = (rest == '0);
               pending_in      = rest;
               state_in        = (rest == '0) ? ST_IDLE : ST_EMIT;
            end else begin
               pending_in = src;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (dp_status.slot_free) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_kind = first_kind;
               dp_cmd.out_last = (rest == '0);
               pending_in      = rest;
               state_in        = (rest == '0) ? ST_IDLE : ST_EMIT;
            end
         end
         ST_RELEASE: begin
            if (!dp_status.rel_more) begin
               // The rejected byte is then evaluated again from the content phase.
               dp_cmd.rel_end = 1'b1;
               state_in       = ST_EVAL;
            end else if (dp_status.slot_free) begin
               dp_cmd.out_load      = 1'b1;
               dp_cmd.out_kind      = mbs_pkg::KIND_BYTE;
               dp_cmd.out_last      = dp_status.rel_last;
               dp_cmd.out_from_held = 1'b1;
               dp_cmd.rel_advance   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

   `MBS_ASSERT_SAME(a_load_needs_slot, clock, reset, dp_cmd.out_load, dp_status.slot_free, "result loaded into a full output register")
   `MBS_ASSERT_SAME(a_emit_has_work, clock, reset, state_ff == ST_EMIT, pending_ff != '0, "emit state with nothing owed")
   `MBS_ASSERT_SAME(a_idle_is_clean, clock, reset, !req_stall, pending_ff == '0, "new item taken while results are still owed")

endmodule

>>> hdl/mbs_datapath.sv
// Datapath of the multipart boundary splitter: boundary and held-byte stores,
// match state, candidate evaluation and the output register. Depends on mbs_pkg and the macros header.
`include "multipart_boundary_splitter_macros.svh"

module mbs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [5:0]            csr_write_data,
   input  logic [1:0]            req_command,
   input  logic [5:0]            req_boundary_position,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_part_byte,
   output logic                  rsp_last_of_run,
   input  mbs_pkg::dp_cmd_type    dp_cmd,
   output mbs_pkg::dp_status_type dp_status
);

   localparam int BND_IDX_W  = mbs_pkg::BND_IDX_W;
   localparam int HELD_IDX_W = mbs_pkg::HELD_IDX_W;
   localparam int HELD_CNT_W = mbs_pkg::HELD_CNT_W;
   localparam int POS_W      = mbs_pkg::POS_W;
   localparam int PAD_W      = mbs_pkg::PAD_W;

   typedef enum logic [2:0] {
      PH_CONTENT,
      PH_CR,
      PH_MARK,
      PH_AFTER,
      PH_DASH,
      PH_MARK_CR
   } phase_type;

   logic [7:0] bnd_mem  [mbs_pkg::MAX_BOUNDARY];
   logic [7:0] held_mem [mbs_pkg::HELD_DEPTH];

   logic [5:0]            boundary_length_ff;
   phase_type             phase_ff, phase_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic [PAD_W-1:0]      padding_ff, padding_in;
   logic [HELD_CNT_W-1:0] held_count_ff, held_count_in;
   logic                  part_open_ff, part_open_in;
   logic                  finished_ff, finished_in;
   logic [HELD_CNT_W-1:0] rel_index_ff;
   logic [HELD_CNT_W-1:0] rel_rd_addr;
   logic [1:0]            cur_command_ff;
   logic [7:0]            cur_byte_ff;
   logic [7:0]            bnd_rd_ff;
   logic [7:0]            held_rd_ff;
   logic                  rsp_valid_ff;
   mbs_pkg::kind_type     rsp_kind_ff;
   logic [7:0]            rsp_part_byte_ff;
   logic                  rsp_last_ff;

   logic [POS_W-1:0]      len_eff;
   logic [POS_W-1:0]      mark_end;
   logic [POS_W-1:0]      pos_minus;
   logic [BND_IDX_W-1:0]  bnd_rd_addr;
   logic [7:0]            mark_char;
   logic                  hold_we;
   mbs_pkg::events_type   ev;
   logic                  reject;

   // Effective boundary length and end of the "--boundary" mark.
   always_comb begin
      if (int'(boundary_length_ff) > mbs_pkg::MAX_BOUNDARY) begin
         len_eff = POS_W'(mbs_pkg::MAX_BOUNDARY);
      end else begin
         len_eff = POS_W'(boundary_length_ff);
      end
      mark_end  = len_eff + POS_W'(2);
      pos_minus = position_ff - POS_W'(2);
      if (position_ff >= POS_W'(2) && int'(pos_minus) < mbs_pkg::MAX_BOUNDARY) begin
         bnd_rd_addr = BND_IDX_W'(pos_minus);
      end else begin
         bnd_rd_addr = '0;
      end
      mark_char = (position_ff < POS_W'(2)) ? mbs_pkg::CH_DASH : bnd_rd_ff;
   end

   // One step of the matcher for the captured item.
   always_comb begin
      phase_type       cur_phase;
      logic [PAD_W-1:0] cur_pad;
      logic            do_hold;
      logic            do_accept;
      logic            closing;
      logic            candidate_ok;

      phase_in      = phase_ff;
      position_in   = position_ff;
      padding_in    = padding_ff;
      held_count_in = held_count_ff;
      part_open_in  = part_open_ff;
      finished_in   = finished_ff;
      hold_we       = 1'b0;
      ev            = '0;
      reject        = 1'b0;
      cur_phase     = phase_ff;
      cur_pad       = padding_ff;
      do_hold       = 1'b0;
      do_accept     = 1'b0;
      closing       = 1'b0;
      candidate_ok  = 1'b0;

      if (cur_command_ff == mbs_pkg::CMD_END) begin
         if (!finished_ff) begin
            candidate_ok = (boundary_length_ff != '0) &&
                           (phase_ff == PH_AFTER ||
                            (phase_ff == PH_MARK && position_ff >= mark_end));
            ev.done    = candidate_ok && part_open_ff;
            ev.discard = candidate_ok || part_open_ff;
            ev.finish  = 1'b1;
         end
         // Re-arm for a new body; the boundary is kept.
         held_count_in = '0;
         part_open_in  = 1'b0;
         finished_in   = 1'b0;
         phase_in      = PH_MARK;
         position_in   = '0;
         padding_in    = '0;
      end else if (cur_command_ff == mbs_pkg::CMD_BODY && !finished_ff &&
                   boundary_length_ff != '0) begin
         // A mark that a shortened boundary already covers counts as complete.
         if (phase_ff == PH_MARK && position_ff >= mark_end) begin
            cur_phase = PH_AFTER;
            cur_pad   = '0;
         end
         phase_in   = cur_phase;
         padding_in = cur_pad;
         unique case (cur_phase)
            PH_CONTENT: begin
               if (cur_byte_ff == mbs_pkg::CH_CR) begin
                  do_hold  = 1'b1;
                  phase_in = PH_CR;
               end else if (cur_byte_ff == mbs_pkg::CH_LF) begin
                  do_hold     = 1'b1;
                  phase_in    = PH_MARK;
                  position_in = '0;
                  padding_in  = '0;
               end else begin
                  ev.content = part_open_ff;
               end
            end
            PH_CR: begin
               if (cur_byte_ff == mbs_pkg::CH_LF) begin
                  do_hold     = 1'b1;
                  phase_in    = PH_MARK;
                  position_in = '0;
                  padding_in  = '0;
               end else begin
                  reject = 1'b1;
               end
            end
            PH_MARK: begin
               if (cur_byte_ff == mark_char) begin
                  do_hold     = 1'b1;
                  position_in = position_ff + POS_W'(1);
                  if (position_ff + POS_W'(1) >= mark_end) begin
                     phase_in   = PH_AFTER;
                     padding_in = '0;
                  end
               end else begin
                  reject = 1'b1;
               end
            end
            PH_AFTER: begin
               if (cur_byte_ff == mbs_pkg::CH_DASH && cur_pad == '0) begin
                  do_hold  = 1'b1;
                  phase_in = PH_DASH;
               end else if (cur_byte_ff == mbs_pkg::CH_SPACE ||
                            cur_byte_ff == mbs_pkg::CH_TAB) begin
                  if (int'(cur_pad) >= mbs_pkg::MAX_PAD) begin
                     reject = 1'b1;
                  end else begin
                     do_hold    = 1'b1;
                     padding_in = cur_pad + PAD_W'(1);
                  end
               end else if (cur_byte_ff == mbs_pkg::CH_CR) begin
                  do_hold  = 1'b1;
                  phase_in = PH_MARK_CR;
               end else if (cur_byte_ff == mbs_pkg::CH_LF) begin
                  do_accept = 1'b1;
               end else begin
                  reject = 1'b1;
               end
            end
            PH_DASH: begin
               if (cur_byte_ff == mbs_pkg::CH_DASH) begin
                  do_accept = 1'b1;
                  closing   = 1'b1;
               end else begin
                  reject = 1'b1;
               end
            end
            PH_MARK_CR: begin
               if (cur_byte_ff == mbs_pkg::CH_LF) begin
                  do_accept = 1'b1;
               end else begin
                  reject = 1'b1;
               end
            end
            default: begin
               reject = 1'b1;
            end
         endcase

         if (do_accept) begin
            held_count_in = '0;
            ev.done       = part_open_ff;
            phase_in      = PH_CONTENT;
            position_in   = '0;
            padding_in    = '0;
            if (closing) begin
               ev.finish    = 1'b1;
               part_open_in = 1'b0;
               finished_in  = 1'b1;
            end else begin
               part_open_in = 1'b1;
            end
         end

         // Held bytes stay counted until the release sweep ends; it sends them only while a part is open.
         if (reject) begin
            phase_in    = PH_CONTENT;
            position_in = '0;
            padding_in  = '0;
         end

         if (do_hold && int'(held_count_ff) < mbs_pkg::HELD_DEPTH) begin
            hold_we       = 1'b1;
            held_count_in = held_count_ff + HELD_CNT_W'(1);
         end
      end
   end

   // Release sweep address: during a sweep held_rd_ff shows the entry at rel_index_ff.
   always_comb begin
      if (dp_cmd.rel_start) begin
         rel_rd_addr = '0;
      end else if (dp_cmd.rel_advance) begin
         rel_rd_addr = rel_index_ff + HELD_CNT_W'(1);
      end else begin
         rel_rd_addr = rel_index_ff;
      end
   end

   always_comb begin
      dp_status           = '0;
      dp_status.ev        = ev;
      dp_status.reject    = reject;
      dp_status.rel_more  = part_open_ff && (rel_index_ff < held_count_ff);
      dp_status.rel_last  = (rel_index_ff + HELD_CNT_W'(1) == held_count_ff) &&
                            (cur_byte_ff == mbs_pkg::CH_CR ||
                             cur_byte_ff == mbs_pkg::CH_LF);
      dp_status.slot_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture && req_command == mbs_pkg::CMD_LOAD &&
          int'(req_boundary_position) < mbs_pkg::MAX_BOUNDARY) begin
         bnd_mem[BND_IDX_W'(req_boundary_position)] <= req_data_byte;
      end
      bnd_rd_ff <= bnd_mem[bnd_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.eval_commit && hold_we) begin
         held_mem[HELD_IDX_W'(held_count_ff)] <= cur_byte_ff;
      end
      if (int'(rel_rd_addr) < mbs_pkg::HELD_DEPTH) begin
         held_rd_ff <= held_mem[HELD_IDX_W'(rel_rd_addr)];
      end else begin
         held_rd_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cur_command_ff <= req_command;
         cur_byte_ff    <= req_data_byte;
      end
      if (dp_cmd.out_load) begin
         rsp_kind_ff <= dp_cmd.out_kind;
         rsp_last_ff <= dp_cmd.out_last;
         if (dp_cmd.out_kind != mbs_pkg::KIND_BYTE) begin
            rsp_part_byte_ff <= '0;
         end else if (dp_cmd.out_from_held) begin
            rsp_part_byte_ff <= held_rd_ff;
         end else begin
            rsp_part_byte_ff <= cur_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_length_ff <= '0;
         phase_ff           <= PH_MARK;
         position_ff        <= '0;
         padding_ff         <= '0;
         held_count_ff      <= '0;
         part_open_ff       <= 1'b0;
         finished_ff        <= 1'b0;
         rel_index_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            boundary_length_ff <= csr_write_data;
         end
         if (dp_cmd.eval_commit) begin
            phase_ff      <= phase_in;
            position_ff   <= position_in;
            padding_ff    <= padding_in;
            held_count_ff <= held_count_in;
            part_open_ff  <= part_open_in;
            finished_ff   <= finished_in;
         end else if (dp_cmd.rel_end) begin
            held_count_ff <= '0;
         end
         rel_index_ff <= rel_rd_addr;
         if (dp_cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_part_byte   = rsp_part_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `MBS_ASSERT_SAME(a_held_bound, clock, reset, 1'b1, int'(held_count_ff) <= mbs_pkg::HELD_DEPTH, "held byte count beyond store depth")
   `MBS_ASSERT_SAME(a_pad_bound, clock, reset, 1'b1, int'(padding_ff) <= mbs_pkg::MAX_PAD, "padding count beyond limit")
   `MBS_ASSERT_SAME(a_release_in_range, clock, reset, dp_cmd.rel_advance, rel_index_ff < held_count_ff, "release sweep past the held bytes")

endmodule

>>> hdl/multipart_boundary_splitter.sv
// Top level of the multipart boundary splitter: controller plus datapath.
// Depends on mbs_pkg, mbs_control and mbs_datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_stall    command, boundary_position, data_byte
//   rsp       out         rsp_valid/rsp_stall    kind, part_byte, last_of_run
//   csr       in          csr_write_enable       csr_write_data (boundary length)
//
// A load or unused command is done at capture; a body byte or end of body is captured,
// then evaluated against the registered boundary read. Its first result is loaded in the
// evaluation state if the output register is free, else in the emit state, like each
// further one. On a failed candidate a release sweep sends the held bytes if a part is
// open, then the byte is evaluated again. Reset is synchronous; the stores need no
// clearing pass. While rsp_stall is high a valid result waits in the output register.

module multipart_boundary_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [5:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [5:0] req_boundary_position,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_part_byte,
   output logic       rsp_last_of_run
);

   mbs_pkg::dp_cmd_type    dp_cmd;
   mbs_pkg::dp_status_type dp_status;

   mbs_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .dp_status   (dp_status),
      .dp_cmd      (dp_cmd)
   );

   mbs_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_command           (req_command),
      .req_boundary_position (req_boundary_position),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_part_byte         (rsp_part_byte),
      .rsp_last_of_run       (rsp_last_of_run),
      .dp_cmd                (dp_cmd),
      .dp_status             (dp_status)
   );

endmodule
